// ----- hw/rtl/wbd_pkg.sv -----
// shared types and constants for the windowed back-reference decoder
// no dependencies; used by windowed_backref_decoder

package wbd_pkg;

    // history window
    localparam int unsigned WindowDepth = 32;
    localparam int unsigned PosWidth    = 5;
    localparam int unsigned CountWidth  = 6;

    localparam logic [7:0] ESCAPE_CODE = 8'hFF;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ESCAPE_END = 2'd1,
        STATUS_DIST_FAR   = 2'd2
    } status_t;

    // control sequencer
    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } state_t;

endpackage

// ----- hw/rtl/wbd_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; used by windowed_backref_decoder for the history window

module wbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the contents before a write to the same address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/windowed_backref_decoder.sv -----
// windowed back-reference decoder: top level with sequencer and output register
// depends on wbd_pkg and wbd_ram
//
// results: a literal or error result is registered in the cycle after its transfer;
//   the first byte of a copy passes the registered history read, then the output register
// flow: literal, escape and error inputs go back to back while the output is free; a copy
//   of n bytes (1 to 8) holds the input off to its end, one history byte per cycle while free
// reset: rst_n clears the sequencer, the chunk state and the output valid flag;
//   the history ram is not cleared, only bytes written in the current chunk are read

module windowed_backref_decoder (
    input  logic        clk,
    input  logic        rst_n,

    // coded input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  logic        s_axis_tlast,   // chunk_last

    // decoded output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic        m_axis_tuser,   // run_last
    output logic        m_axis_tlast    // chunk_end
);

    localparam int unsigned PW = wbd_pkg::PosWidth;
    localparam int unsigned CW = wbd_pkg::CountWidth;
    localparam logic [CW-1:0] WIN = CW'(wbd_pkg::WindowDepth);

    // sequencer
    wbd_pkg::state_t state_reg, state_next;

    // chunk state
    logic [PW-1:0] write_pos_reg, write_pos_next;
    logic [CW-1:0] produced_reg, produced_next;
    logic          escape_reg, escape_next;
    logic          discard_reg, discard_next;

    // copy in flight
    logic [CW-1:0] dist_reg, dist_next;
    logic [2:0]    remain_reg, remain_next;
    logic          last_reg, last_next;
    logic          fwd_reg, fwd_next;
    logic [7:0]    fwd_data_reg, fwd_data_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    wbd_pkg::status_t out_status_reg, out_status_next;
    logic          out_run_last_reg, out_run_last_next;
    logic          out_chunk_end_reg, out_chunk_end_next;

    // history ram ports
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [PW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // decode of the offered input
    logic          in_xfer;
    logic          out_free;
    logic [7:0]    code;
    logic [CW-1:0] dist_in;
    logic          dist_far;
    logic          is_escape;
    logic          copy_start;
    logic [7:0]    copy_byte;
    logic [CW-1:0] produced_inc;
    logic [PW-1:0] pos_inc;

    wbd_ram #(
        .WIDTH (8),
        .DEPTH (wbd_pkg::WindowDepth)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a new result may be loaded when the output register is empty or draining
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == wbd_pkg::ST_IDLE) && out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign code      = s_axis_tdata;
    assign is_escape = (code == wbd_pkg::ESCAPE_CODE);
    // distance 1..32, where a zero upper field means the full window
    assign dist_in   = WIN - {1'b0, code[7:3]};
    assign dist_far  = dist_in > produced_reg;
    assign copy_start = in_xfer && !discard_reg && !escape_reg && !is_escape && !dist_far;

    // byte just written is bypassed when the copy distance is one
    assign copy_byte    = fwd_reg ? fwd_data_reg : ram_rdata;
    assign produced_inc = (produced_reg == WIN) ? produced_reg : produced_reg + CW'(1);
    assign pos_inc      = write_pos_reg + PW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wbd_pkg::ST_IDLE:
            begin
                if (copy_start)
                begin
                    state_next = wbd_pkg::ST_COPY;
                end
            end
            wbd_pkg::ST_COPY:
            begin
                if (out_free && remain_reg == '0)
                begin
                    state_next = wbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wbd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        write_pos_next     = write_pos_reg;
        produced_next      = produced_reg;
        escape_next        = escape_reg;
        discard_next       = discard_reg;
        dist_next          = dist_reg;
        remain_next        = remain_reg;
        last_next          = last_reg;
        fwd_next           = fwd_reg;
        fwd_data_next      = fwd_data_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_byte_next      = out_byte_reg;
        out_status_next    = out_status_reg;
        out_run_last_next  = out_run_last_reg;
        out_chunk_end_next = out_chunk_end_reg;
        ram_we             = 1'b0;
        ram_waddr          = write_pos_reg;
        ram_wdata          = code;
        ram_re             = 1'b0;
        ram_raddr          = write_pos_reg - dist_in[PW-1:0];

        unique case (state_reg)
            wbd_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (discard_reg)
                    begin
                        // rest of a failed chunk: no result
                        if (s_axis_tlast)
                        begin
                            discard_next = 1'b0;
                            escape_next  = 1'b0;
                            write_pos_next = '0;
                            produced_next  = '0;
                        end
                    end
                    else if (escape_reg)
                    begin
                        // literal byte after an escape
                        ram_we             = 1'b1;
                        escape_next        = 1'b0;
                        write_pos_next     = pos_inc;
                        produced_next      = produced_inc;
                        out_valid_next     = 1'b1;
                        out_byte_next      = code;
                        out_status_next    = wbd_pkg::STATUS_OK;
                        out_run_last_next  = 1'b1;
                        out_chunk_end_next = s_axis_tlast;
                        if (s_axis_tlast)
                        begin
                            write_pos_next = '0;
                            produced_next  = '0;
                        end
                    end
                    else if (is_escape)
                    begin
                        if (s_axis_tlast)
                        begin
                            // escape with nothing after it
                            out_valid_next     = 1'b1;
                            out_byte_next      = '0;
                            out_status_next    = wbd_pkg::STATUS_ESCAPE_END;
                            out_run_last_next  = 1'b1;
                            out_chunk_end_next = 1'b1;
                            write_pos_next     = '0;
                            produced_next      = '0;
                        end
                        else
                        begin
                            escape_next = 1'b1;
                        end
                    end
                    else if (dist_far)
                    begin
                        // reference reaches before the start of the chunk
                        out_valid_next     = 1'b1;
                        out_byte_next      = '0;
                        out_status_next    = wbd_pkg::STATUS_DIST_FAR;
                        out_run_last_next  = 1'b1;
                        out_chunk_end_next = s_axis_tlast;
                        if (s_axis_tlast)
                        begin
                            write_pos_next = '0;
                            produced_next  = '0;
                        end
                        else
                        begin
                            discard_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // start of a copy: first source read
                        ram_re      = 1'b1;
                        dist_next   = dist_in;
                        remain_next = code[2:0];
                        last_next   = s_axis_tlast;
                        fwd_next    = 1'b0;
                    end
                end
            end
            wbd_pkg::ST_COPY:
            begin
                if (out_free)
                begin
                    ram_we             = 1'b1;
                    ram_wdata          = copy_byte;
                    write_pos_next     = pos_inc;
                    produced_next      = produced_inc;
                    out_valid_next     = 1'b1;
                    out_byte_next      = copy_byte;
                    out_status_next    = wbd_pkg::STATUS_OK;
                    out_run_last_next  = (remain_reg == '0);
                    out_chunk_end_next = (remain_reg == '0) && last_reg;
                    if (remain_reg != '0)
                    begin
                        // next source byte; distance one hits the slot written now
                        ram_re        = 1'b1;
                        ram_raddr     = pos_inc - dist_reg[PW-1:0];
                        remain_next   = remain_reg - 3'd1;
                        fwd_next      = (dist_reg == CW'(1));
                        fwd_data_next = copy_byte;
                    end
                    else if (last_reg)
                    begin
                        write_pos_next = '0;
                        produced_next  = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wbd_pkg::ST_IDLE;
            write_pos_reg <= '0;
            produced_reg  <= '0;
            escape_reg    <= 1'b0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            write_pos_reg <= write_pos_next;
            produced_reg  <= produced_next;
            escape_reg    <= escape_next;
            discard_reg   <= discard_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dist_reg          <= dist_next;
        remain_reg        <= remain_next;
        last_reg          <= last_next;
        fwd_reg           <= fwd_next;
        fwd_data_reg      <= fwd_data_next;
        out_byte_reg      <= out_byte_next;
        out_status_reg    <= out_status_next;
        out_run_last_reg  <= out_run_last_next;
        out_chunk_end_reg <= out_chunk_end_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_status_reg, out_byte_reg};
    assign m_axis_tuser  = out_run_last_reg;
    assign m_axis_tlast  = out_chunk_end_reg;

endmodule
